FILE: rtl/core/itoaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoaf_pkg;

    typedef logic [7:0] char_t;
    typedef logic [3:0] nibble_t;

    // Request type codes.
    localparam logic [1:0] TYPE_SDEC = 2'd0;
    localparam logic [1:0] TYPE_UDEC = 2'd1;
    localparam logic [1:0] TYPE_HEXL = 2'd2;
    localparam logic [1:0] TYPE_HEXU = 2'd3;

    // Sign mode codes for non-negative signed decimal values.
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    localparam int VALUE_W    = 64;
    localparam int BCD_DIGITS = 20;
    localparam int HEX_DIGITS = 16;
    localparam int DIGIT_W    = BCD_DIGITS * 4;
    localparam int ND_W       = 5;

    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_PLUS  = 8'h2B;
    localparam char_t CHAR_MINUS = 8'h2D;
    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_X_LO  = 8'h78;
    localparam char_t CHAR_X_UP  = 8'h58;

    // Double-dabble correction: a BCD digit of five or more gets three added
    // before the shift so that it carries into the next digit.
    function automatic nibble_t bcd_adjust(input nibble_t d);
        bcd_adjust = (d >= 4'd5) ? (d + 4'd3) : d;
    endfunction

    // ASCII for one digit; decimal digits never reach the letter range.
    function automatic char_t digit_char(input nibble_t d, input logic upper);
        if (d < 4'd10)
        begin
            digit_char = CHAR_ZERO + {4'h0, d};
        end
        else if (upper)
        begin
            digit_char = 8'h37 + {4'h0, d};
        end
        else
        begin
            digit_char = 8'h57 + {4'h0, d};
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/integer_to_ascii_formatter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer to ASCII formatter. A request is taken when start is high and busy
// is low; the block then streams the formatted text one character per beat on
// out_char, each beat marked by char_valid for exactly one cycle, with
// last_char set on the final beat. The receiver cannot stall the stream, so it
// must take a beat every cycle that char_valid is high. A decimal request
// first runs shift-and-add-three conversion through a 20-digit BCD shift
// register, then strips leading zero digits one per cycle, passes through
// a planning state and then sends one cycle per character, at most
// MAX_WIDTH + 1 characters. A hex request skips the conversion: it strips
// leading zero nibbles one per cycle, plans, and sends one cycle per
// character. A decimal request with value zero, precision zero, width zero
// and no sign produces no beat at all; busy simply drops after the planning
// state. The BCD conversion is the dominant cost and is the reason a decimal
// item takes longer than a hex one.
module integer_to_ascii_formatter_unit #(
    parameter int MAX_WIDTH = 40
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  req_type,
    input  wire  [63:0] value,
    input  wire  [5:0]  field_width,
    input  wire         has_precision,
    input  wire  [5:0]  min_digits,
    input  wire         right_align,
    input  wire         zero_fill,
    input  wire         alt_prefix,
    input  wire  [1:0]  sign_mode,
    output logic        char_valid,
    output logic [7:0]  out_char,
    output logic        last_char
);

    // Counter width: holds MAX_WIDTH + 1, the longest possible text.
    localparam int CW = $clog2(MAX_WIDTH + 2);
    localparam int DW = itoaf_pkg::DIGIT_W;
    localparam int NW = itoaf_pkg::ND_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_PLAN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]    state_reg, state_next;

    // Request fields held for the whole item.
    logic [1:0]    type_reg, type_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] prec_reg, prec_next;
    logic          right_reg, right_next;
    logic          zfill_reg, zfill_next;
    logic          alt_reg, alt_next;
    logic [1:0]    smode_reg, smode_next;
    logic          neg_reg, neg_next;

    // Conversion datapath: magnitude shifts out MSB first into the BCD register.
    logic [63:0]   mag_reg, mag_next;
    logic [DW-1:0] dig_reg, dig_next;
    logic [5:0]    bit_cnt_reg, bit_cnt_next;
    logic [NW-1:0] nd_reg, nd_next;

    // Emission run lengths, drained in priority order.
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [1:0]    cnt_p_reg, cnt_p_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] cnt_z_reg, cnt_z_next;
    logic [NW-1:0] cnt_d_reg, cnt_d_next;
    logic [CW-1:0] cnt_t_reg, cnt_t_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          fill_b_zero_reg, fill_b_zero_next;
    logic          fill_t_zero_reg, fill_t_zero_next;

    logic          char_valid_reg, char_valid_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          last_char_reg, last_char_next;

    logic          is_dec;
    logic          upper;
    logic [3:0]    top_nib;
    logic [DW-1:0] dig_adj;
    logic [CW-1:0] nd_ext;
    logic [CW-1:0] dec_total;
    logic [CW-1:0] body;
    logic [CW-1:0] pad;
    logic [CW-1:0] span;
    logic          sign_len;
    logic [7:0]    sign_char;
    logic [NW-1:0] nd_min;

    assign is_dec  = (type_reg == itoaf_pkg::TYPE_SDEC) || (type_reg == itoaf_pkg::TYPE_UDEC);
    assign upper   = (type_reg == itoaf_pkg::TYPE_HEXU);
    assign top_nib = dig_reg[DW-1 -: 4];
    assign nd_min  = is_dec ? NW'(0) : NW'(1);

    always_comb
    begin
        for (int i = 0; i < itoaf_pkg::BCD_DIGITS; i++)
        begin
            dig_adj[i*4 +: 4] = itoaf_pkg::bcd_adjust(dig_reg[i*4 +: 4]);
        end
    end

    // Planning arithmetic: digit body, padding and total character count.
    always_comb
    begin
        nd_ext    = CW'(nd_reg);
        dec_total = (nd_ext > prec_reg) ? nd_ext : prec_reg;
        body      = is_dec ? dec_total : (nd_ext + (alt_reg ? CW'(2) : CW'(0)));
        pad       = (width_reg > body) ? (width_reg - body) : CW'(0);
        span      = (width_reg > body) ? width_reg : body;
        sign_len  = (type_reg == itoaf_pkg::TYPE_SDEC)
                    && (neg_reg || (smode_reg != itoaf_pkg::SIGN_NONE));
        if (neg_reg)
        begin
            sign_char = itoaf_pkg::CHAR_MINUS;
        end
        else if (smode_reg == itoaf_pkg::SIGN_SPACE)
        begin
            sign_char = itoaf_pkg::CHAR_SPACE;
        end
        else
        begin
            sign_char = itoaf_pkg::CHAR_PLUS;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        type_next        = type_reg;
        width_next       = width_reg;
        prec_next        = prec_reg;
        right_next       = right_reg;
        zfill_next       = zfill_reg;
        alt_next         = alt_reg;
        smode_next       = smode_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        dig_next         = dig_reg;
        bit_cnt_next     = bit_cnt_reg;
        nd_next          = nd_reg;
        cnt_a_next       = cnt_a_reg;
        cnt_p_next       = cnt_p_reg;
        cnt_b_next       = cnt_b_reg;
        cnt_z_next       = cnt_z_reg;
        cnt_d_next       = cnt_d_reg;
        cnt_t_next       = cnt_t_reg;
        remain_next      = remain_reg;
        fill_b_zero_next = fill_b_zero_reg;
        fill_t_zero_next = fill_t_zero_reg;
        char_valid_next  = 1'b0;
        out_char_next    = out_char_reg;
        last_char_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    type_next  = req_type;
                    width_next = ({1'b0, field_width} > 7'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                                     : CW'(field_width);
                    if (!has_precision)
                    begin
                        prec_next = CW'(1);
                    end
                    else if ({1'b0, min_digits} > 7'(MAX_WIDTH))
                    begin
                        prec_next = CW'(MAX_WIDTH);
                    end
                    else
                    begin
                        prec_next = CW'(min_digits);
                    end
                    right_next   = right_align;
                    zfill_next   = zero_fill;
                    alt_next     = alt_prefix;
                    smode_next   = sign_mode;
                    neg_next     = (req_type == itoaf_pkg::TYPE_SDEC) && value[63];
                    mag_next     = ((req_type == itoaf_pkg::TYPE_SDEC) && value[63])
                                   ? (64'd0 - value) : value;
                    bit_cnt_next = 6'd0;
                    if (req_type[1])
                    begin
                        dig_next   = {value, {(DW - itoaf_pkg::VALUE_W){1'b0}}};
                        nd_next    = NW'(itoaf_pkg::HEX_DIGITS);
                        state_next = S_NORM;
                    end
                    else
                    begin
                        dig_next   = '0;
                        nd_next    = NW'(itoaf_pkg::BCD_DIGITS);
                        state_next = S_CONV;
                    end
                end
            end

            S_CONV:
            begin
                // One magnitude bit per cycle into the BCD register.
                dig_next     = {dig_adj[DW-2:0], mag_reg[63]};
                mag_next     = {mag_reg[62:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 6'd1;
                if (bit_cnt_reg == 6'd63)
                begin
                    state_next = S_NORM;
                end
            end

            S_NORM:
            begin
                // Strip leading zero digits; hex always keeps one digit.
                if ((nd_reg > nd_min) && (top_nib == 4'd0))
                begin
                    dig_next = {dig_reg[DW-5:0], 4'd0};
                    nd_next  = nd_reg - NW'(1);
                end
                else
                begin
                    state_next = S_PLAN;
                end
            end

            S_PLAN:
            begin
                cnt_d_next  = nd_reg;
                cnt_t_next  = right_reg ? CW'(0) : pad;
                remain_next = span + CW'(sign_len);
                if (is_dec)
                begin
                    cnt_a_next       = CW'(0);
                    cnt_p_next       = {1'b0, sign_len};
                    cnt_b_next       = right_reg ? pad : CW'(0);
                    cnt_z_next       = dec_total - nd_ext;
                    fill_b_zero_next = zfill_reg;
                    fill_t_zero_next = zfill_reg;
                end
                else
                begin
                    cnt_a_next       = (right_reg && !zfill_reg) ? pad : CW'(0);
                    cnt_p_next       = alt_reg ? 2'd2 : 2'd0;
                    cnt_b_next       = (right_reg && zfill_reg) ? pad : CW'(0);
                    cnt_z_next       = CW'(0);
                    fill_b_zero_next = 1'b1;
                    fill_t_zero_next = 1'b0;
                end
                if ((span + CW'(sign_len)) == CW'(0))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                char_valid_next = 1'b1;
                remain_next     = remain_reg - CW'(1);
                last_char_next  = (remain_reg == CW'(1));
                if (remain_reg == CW'(1))
                begin
                    state_next = S_IDLE;
                end
                if (cnt_a_reg != CW'(0))
                begin
                    out_char_next = itoaf_pkg::CHAR_SPACE;
                    cnt_a_next    = cnt_a_reg - CW'(1);
                end
                else if (cnt_p_reg != 2'd0)
                begin
                    if (cnt_p_reg == 2'd2)
                    begin
                        out_char_next = itoaf_pkg::CHAR_ZERO;
                    end
                    else if (is_dec)
                    begin
                        out_char_next = sign_char;
                    end
                    else
                    begin
                        out_char_next = upper ? itoaf_pkg::CHAR_X_UP : itoaf_pkg::CHAR_X_LO;
                    end
                    cnt_p_next = cnt_p_reg - 2'd1;
                end
                else if (cnt_b_reg != CW'(0))
                begin
                    out_char_next = fill_b_zero_reg ? itoaf_pkg::CHAR_ZERO
                                                    : itoaf_pkg::CHAR_SPACE;
                    cnt_b_next    = cnt_b_reg - CW'(1);
                end
                else if (cnt_z_reg != CW'(0))
                begin
                    out_char_next = itoaf_pkg::CHAR_ZERO;
                    cnt_z_next    = cnt_z_reg - CW'(1);
                end
                else if (cnt_d_reg != NW'(0))
                begin
                    out_char_next = itoaf_pkg::digit_char(top_nib, upper);
                    dig_next      = {dig_reg[DW-5:0], 4'd0};
                    cnt_d_next    = cnt_d_reg - NW'(1);
                end
                else
                begin
                    out_char_next = fill_t_zero_reg ? itoaf_pkg::CHAR_ZERO
                                                    : itoaf_pkg::CHAR_SPACE;
                    cnt_t_next    = cnt_t_reg - CW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            char_valid_reg <= 1'b0;
            last_char_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
            last_char_reg  <= last_char_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg        <= type_next;
        width_reg       <= width_next;
        prec_reg        <= prec_next;
        right_reg       <= right_next;
        zfill_reg       <= zfill_next;
        alt_reg         <= alt_next;
        smode_reg       <= smode_next;
        neg_reg         <= neg_next;
        mag_reg         <= mag_next;
        dig_reg         <= dig_next;
        bit_cnt_reg     <= bit_cnt_next;
        nd_reg          <= nd_next;
        cnt_a_reg       <= cnt_a_next;
        cnt_p_reg       <= cnt_p_next;
        cnt_b_reg       <= cnt_b_next;
        cnt_z_reg       <= cnt_z_next;
        cnt_d_reg       <= cnt_d_next;
        cnt_t_reg       <= cnt_t_next;
        remain_reg      <= remain_next;
        fill_b_zero_reg <= fill_b_zero_next;
        fill_t_zero_reg <= fill_t_zero_next;
        out_char_reg    <= out_char_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign char_valid = char_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_char_reg;

    // A beat on the output can only come from the emission state.
    a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ($past(state_reg) == S_EMIT))
        else $error("character beat without emission");

    // The emission state always has at least one character left to send.
    a_emit_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (remain_reg != CW'(0)))
        else $error("emission with nothing remaining");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // The final beat of an item is never directly followed by another beat.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && last_char) |=> !char_valid)
        else $error("beat directly after final character");

endmodule

`default_nettype wire
